// File: sv/linear_probe_hash_table_assert.svh
// Assertion macros for the linear probe hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LPHT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpht assertion failed");

// Check that a stalled beat keeps its payload.
`define LPHT_ASSERT_HOLD(name, vld, rdy, sig) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error("lpht stalled beat changed");

`endif

// File: sv/lpht_pkg.sv
// Package: types, codes and hash helpers of the linear probe hash table.
`default_nettype none
package lpht_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned KeyBytesDefault   = 8;
  localparam int unsigned ValueWidthDefault = 32;

  localparam logic [63:0] HashBasis = 64'd14695981039346656037;
  localparam int unsigned HashKeep  = 16;

  localparam logic [3:0] SizeLog2Min   = 4'd4;
  localparam logic [3:0] SizeLog2Max   = 4'd10;
  localparam logic [3:0] SizeLog2Reset = 4'd4;

  // request codes
  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] stored_value;
    logic        load_high;
  } rsp_t;

  // hashed request handed from front to back
  typedef struct packed {
    logic [1:0]          req_type;
    logic [63:0]         key;
    logic [3:0]          key_len;
    logic [31:0]         value;
    logic [HashKeep-1:0] hash;
  } item_t;

  // one FNV-1a round; the prime is 2^40 + 0x1b3, so multiply by shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage
`default_nettype wire

// File: sv/linear_probe_hash_table.sv
// Top level: open addressing hash table with linear probing and FNV-1a keys.
// Requests arrive as beats on the in channel (valid/ready): put, get or
// remove of a key of up to eight bytes. Each request yields exactly one
// response beat on the out channel, in request order. The cfg channel
// writes the log2 table size; it is always ready, and the user must write
// it only while the table is idle; the block itself does not enforce this.
// The front hashes one key byte per cycle and takes no new request until
// it hands the item to a two-entry queue. The back works on one request at
// a time: it reads one slot at a time over a registered read of its slot
// memories, and waits in its compare state while the output register holds
// an unaccepted response. Requests follow at the slower of the two; each
// passes the front's hash, the queue, the back's idle, read and compare
// states and the output register. After reset, in_ready stays low while
// the back clears every slot mark; cfg writes are taken during that pass.
// A stalled response waits in the output register while the front keeps
// taking and hashing the next requests until the queue fills.
`default_nettype none
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = lpht_pkg::TableDepthDefault,
  parameter int unsigned KEY_BYTES   = lpht_pkg::KeyBytesDefault,
  parameter int unsigned VALUE_WIDTH = lpht_pkg::ValueWidthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lpht_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lpht_pkg::rsp_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [3:0]     cfg_data_i
);

  logic [3:0]      size_log2_q;
  logic            back_ready, push, full, pop, q_valid;
  lpht_pkg::item_t f_item, q_item;

  // hold the size register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= lpht_pkg::SizeLog2Reset;
    end else if (cfg_valid_i) begin
      size_log2_q <= cfg_data_i;
    end
  end

  lpht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i, .rst_ni,
    .enable_i   (back_ready),
    .in_valid_i, .in_ready_o, .in_data_i,
    .push_o     (push),
    .full_i     (full),
    .item_o     (f_item)
  );

  lpht_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  lpht_back #(
    .TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i, .rst_ni,
    .size_log2_i (size_log2_q),
    .ready_o     (back_ready),
    .q_valid_i   (q_valid),
    .q_data_i    (q_item),
    .q_pop_o     (pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire

// File: sv/lpht_front.sv
// Front: accept requests, normalize the key and hash it one byte per cycle.
`default_nettype none
module lpht_front #(
  parameter int unsigned KEY_BYTES = lpht_pkg::KeyBytesDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           enable_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lpht_pkg::req_t in_data_i,
  output logic                push_o,
  input  wire logic           full_i,
  output lpht_pkg::item_t     item_o
);

  logic        busy_q, busy_d;
  logic [63:0] hash_q, hash_d;
  logic [63:0] key_q;
  logic [3:0]  len_q, cnt_q, cnt_d;
  logic [1:0]  type_q;
  logic [31:0] value_q;
  logic [3:0]  len_sat;
  logic [63:0] key_norm;
  logic [63:0] key_shift;
  logic        accept;

  assign in_ready_o = enable_i && !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // saturate the length and drop key bytes beyond it
  always_comb begin
    len_sat = (in_data_i.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_data_i.key_length;
    for (int i = 0; i < 8; i++) begin
      key_norm[i*8 +: 8] = (4'(i) < len_sat) ? in_data_i.key_bytes[i*8 +: 8] : 8'd0;
    end
  end

  assign key_shift = key_q >> {cnt_q[2:0], 3'b000};

  // advance the hash, then hand the beat to the queue
  always_comb begin
    busy_d = busy_q;
    hash_d = hash_q;
    cnt_d  = cnt_q;
    push_o = 1'b0;
    if (busy_q) begin
      if (cnt_q == len_q) begin
        if (!full_i) begin
          push_o = 1'b1;
          busy_d = 1'b0;
        end
      end else begin
        hash_d = lpht_pkg::fnv_step(hash_q, key_shift[7:0]);
        cnt_d  = cnt_q + 4'd1;
      end
    end else if (accept) begin
      busy_d = 1'b1;
      hash_d = lpht_pkg::HashBasis;
      cnt_d  = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    cnt_q  <= cnt_d;
    if (accept) begin
      key_q   <= key_norm;
      len_q   <= len_sat;
      type_q  <= in_data_i.req_type;
      value_q <= in_data_i.new_value;
    end
  end

  assign item_o.req_type = type_q;
  assign item_o.key      = key_q;
  assign item_o.key_len  = len_q;
  assign item_o.value    = value_q;
  assign item_o.hash     = hash_q[lpht_pkg::HashKeep-1:0];

endmodule
`default_nettype wire

// File: sv/lpht_queue.sv
// Two-entry queue of hashed requests between front and back.
`default_nettype none
module lpht_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lpht_pkg::item_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output lpht_pkg::item_t      data_o
);

  lpht_pkg::item_t entry_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

// File: sv/lpht_back.sv
// Back: clear the slot marks, walk the probe sequence and commit each request.
`default_nettype none
module lpht_back #(
  parameter int unsigned TABLE_DEPTH = lpht_pkg::TableDepthDefault,
  parameter int unsigned KEY_BYTES   = lpht_pkg::KeyBytesDefault,
  parameter int unsigned VALUE_WIDTH = lpht_pkg::ValueWidthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [3:0]      size_log2_i,
  output logic                 ready_o,
  input  wire logic            q_valid_i,
  input  wire lpht_pkg::item_t q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lpht_pkg::rsp_t       out_data_o
);

  localparam int unsigned IdxW    = $clog2(TABLE_DEPTH);
  localparam int unsigned DepthL2 = ((1 << IdxW) > TABLE_DEPTH) ? IdxW - 1 : IdxW;
  localparam int unsigned CntW    = IdxW + 1;
  localparam int unsigned LoadW   = IdxW + 5;
  localparam int unsigned KeyW    = 8 * KEY_BYTES;
  localparam int unsigned ValW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned DataW   = KeyW + 4 + ValW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0]       mark_mem [TABLE_DEPTH];
  logic [DataW-1:0] data_mem [TABLE_DEPTH];

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  clr_q;
  lpht_pkg::item_t  item_q;
  logic [IdxW-1:0]  idx_q, idx_d, steps_q, steps_d, tomb_q, tomb_d;
  logic             tseen_q, tseen_d;
  logic [CntW-1:0]  live_q, live_d, tcnt_q, tcnt_d;
  logic [1:0]       mark_rd_q;
  logic [DataW-1:0] data_rd_q;
  logic             out_valid_q;
  lpht_pkg::rsp_t   out_q, rsp_d;

  logic [3:0]       l2_clamp, l2_eff;
  logic [IdxW-1:0]  mask;
  logic [KeyW-1:0]  key_cmp;
  logic [ValW-1:0]  val_in, val_rd;
  logic             is_nop, is_empty, is_tomb, is_match, is_last, fin, out_free, commit;
  logic             tseen_now;
  logic [IdxW-1:0]  tomb_at;
  logic             mark_we, data_we;
  logic [IdxW-1:0]  mark_wa, data_wa;
  logic [1:0]       mark_wd;
  logic [DataW-1:0] data_wd;
  logic [CntW-1:0]  sum;
  logic [LoadW-1:0] load_lhs, load_rhs;

  // active size: clamp the register, then cap at the store depth
  always_comb begin
    l2_clamp = size_log2_i;
    if (l2_clamp < lpht_pkg::SizeLog2Min) l2_clamp = lpht_pkg::SizeLog2Min;
    if (l2_clamp > lpht_pkg::SizeLog2Max) l2_clamp = lpht_pkg::SizeLog2Max;
    l2_eff = (l2_clamp > 4'(DepthL2)) ? 4'(DepthL2) : l2_clamp;
    for (int i = 0; i < IdxW; i++) mask[i] = (5'(i) < {1'b0, l2_eff});
  end

  assign ready_o     = (state_q != S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;

  assign key_cmp  = item_q.key[KeyW-1:0];
  assign val_in   = item_q.value[ValW-1:0];
  assign val_rd   = data_rd_q[ValW-1:0];

  // classify the slot just read
  assign is_nop    = (item_q.req_type != lpht_pkg::REQ_PUT) &&
                     (item_q.req_type != lpht_pkg::REQ_GET) &&
                     (item_q.req_type != lpht_pkg::REQ_REMOVE);
  assign is_empty  = (mark_rd_q == lpht_pkg::MARK_EMPTY);
  assign is_tomb   = (mark_rd_q == lpht_pkg::MARK_TOMB);
  assign is_match  = (mark_rd_q == lpht_pkg::MARK_LIVE) &&
                     (data_rd_q[ValW +: 4] == item_q.key_len) &&
                     (data_rd_q[ValW+4 +: KeyW] == key_cmp);
  assign is_last   = (steps_q == mask);
  assign fin       = is_nop || is_empty || is_match || is_last;
  assign commit    = (state_q == S_CMP) && fin && out_free;
  assign tseen_now = tseen_q || is_tomb;
  assign tomb_at   = tseen_q ? tomb_q : idx_q;

  // decide the mark clears after reset and the outcome and store updates of a finished probe
  always_comb begin
    rsp_d        = '0;
    rsp_d.status = lpht_pkg::ST_NOT_FOUND;
    live_d       = live_q;
    tcnt_d       = tcnt_q;
    mark_we      = 1'b0;
    mark_wa      = idx_q;
    mark_wd      = lpht_pkg::MARK_LIVE;
    data_we      = 1'b0;
    data_wa      = idx_q;
    data_wd      = {key_cmp, item_q.key_len, val_in};
    if (state_q == S_CLEAR) begin
      mark_we = 1'b1;
      mark_wa = clr_q;
      mark_wd = lpht_pkg::MARK_EMPTY;
    end else if (commit && !is_nop) begin
      case (item_q.req_type)
        lpht_pkg::REQ_PUT: begin
          if (is_match) begin
            data_we      = 1'b1;
            rsp_d.status = lpht_pkg::ST_DONE;
          end else if (is_empty || tseen_now) begin
            mark_we      = 1'b1;
            data_we      = 1'b1;
            mark_wa      = tseen_now ? tomb_at : idx_q;
            data_wa      = mark_wa;
            if (tseen_now && tcnt_q != '0) tcnt_d = tcnt_q - CntW'(1);
            live_d       = live_q + CntW'(1);
            rsp_d.status = lpht_pkg::ST_DONE;
          end else begin
            rsp_d.status = lpht_pkg::ST_FULL;
          end
        end
        lpht_pkg::REQ_GET: begin
          if (is_match) begin
            rsp_d.status       = lpht_pkg::ST_DONE;
            rsp_d.stored_value = 32'(val_rd);
          end
        end
        lpht_pkg::REQ_REMOVE: begin
          if (is_match) begin
            mark_we      = 1'b1;
            mark_wd      = lpht_pkg::MARK_TOMB;
            if (live_q != '0) live_d = live_q - CntW'(1);
            tcnt_d       = tcnt_q + CntW'(1);
            rsp_d.status = lpht_pkg::ST_DONE;
          end
        end
        default: ;
      endcase
    end
    // load flag after the update: used*10 > size*7
    sum             = live_d + tcnt_d;
    load_lhs        = (LoadW'(sum) << 3) + (LoadW'(sum) << 1);
    load_rhs        = (LoadW'({1'b0, mask} + CntW'(1)) << 3) -
                      LoadW'({1'b0, mask} + CntW'(1));
    rsp_d.load_high = (load_lhs > load_rhs);
  end

  // sequence the probe walk
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    steps_d = steps_q;
    tseen_d = tseen_q;
    tomb_d  = tomb_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == IdxW'(TABLE_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i) begin
          idx_d   = q_data_i.hash[IdxW-1:0] & mask;
          steps_d = '0;
          tseen_d = 1'b0;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (commit) begin
          state_d = S_IDLE;
        end else if (!fin) begin
          if (is_tomb && !tseen_q) tomb_d = idx_q;
          tseen_d = tseen_now;
          idx_d   = (idx_q + IdxW'(1)) & mask;
          steps_d = steps_q + IdxW'(1);
          state_d = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      live_q      <= '0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + IdxW'(1);
      if (commit) begin
        live_q      <= live_d;
        tcnt_q      <= tcnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    steps_q <= steps_d;
    tseen_q <= tseen_d;
    tomb_q  <= tomb_d;
    if (q_pop_o) item_q <= q_data_i;
    if (commit)  out_q  <= rsp_d;
  end

  // slot store: one write and one registered read per memory
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (data_we) data_mem[data_wa] <= data_wd;
    if (state_q == S_READ) begin
      mark_rd_q <= mark_mem[idx_q];
      data_rd_q <= data_mem[idx_q];
    end
  end

endmodule
`default_nettype wire

// File: sv/lpht_checker.sv
// Port checker for the linear probe hash table, bound to the top level.
`default_nettype none
`include "linear_probe_hash_table_assert.svh"
module lpht_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire lpht_pkg::req_t in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire lpht_pkg::rsp_t out_data_o,
  input wire logic           cfg_valid_i,
  input wire logic           cfg_ready_o,
  input wire logic [3:0]     cfg_data_i
);

  `LPHT_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_data_o)
  `LPHT_ASSERT(a_status_code, out_valid_o |-> (out_data_o.status != 2'd3))
  `LPHT_ASSERT(a_value_only_found, (out_valid_o && out_data_o.stored_value != 32'd0) |-> (out_data_o.status == lpht_pkg::ST_DONE))
  `LPHT_ASSERT(a_clear_after_reset, $rose(rst_ni) |-> !in_ready_o)

endmodule
bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
`default_nettype wire
